### hw/rtl/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix fade scanner package
// Request and status types, command codes and fixed field widths.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned OUT_ROWS    = 6;
  localparam int unsigned ROW_IDX_W   = 3;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [LEVEL_W-1:0] FULL_ON = 8'd255;

  localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT    = 1'b1;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_SCALE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_OUT
  } top_st_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_SCALE,
    E_SET_RD,
    E_SET_WR,
    E_SCAN,
    E_DONE
  } eng_st_e;

  typedef struct packed {
    cmd_e                command;
    logic [5:0]          led_index;
    logic                led_lit;
    logic [5:0]          scale_index;
    logic [LEVEL_W-1:0]  scale_value;
  } req_t;

  typedef struct packed {
    logic [STEP_W-1:0] fade_step;
    logic              invert_pwm;
  } cfg_t;

  typedef struct packed {
    logic                 done;
    logic                 row_vld;
    logic [ROW_IDX_W-1:0] row_idx;
    logic [LEVEL_W-1:0]   level;
  } stat_t;

endpackage

### hw/rtl/led_matrix_fade_scanner.sv
// ----------------------------------------------------------------------------
// LED matrix fade scanner
// Scans a multiplexed LED matrix one column per scan request and fades each
// LED toward its on/off target through a loadable intensity scale table.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: command; tdata: led fields
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: column, six row levels
// cfg       in   cfg_we_i (no wait)             cfg_addr_i, cfg_wdata_i
//
// A scan request raises its result after the row engine has read one LED per
// cycle, its fade stepper and scale lookup have added two stages, the sequencer
// has seen the pipeline drain and its E_DONE state has flagged done.
// Target updates, scale writes and unknown commands return no result.
// Input ready drops from an accepted request until its result is taken or,
// for a request without a result, until the engine flags done.
// Reset clears all targets, fade counters, scale entries and the column.
// ----------------------------------------------------------------------------
module led_matrix_fade_scanner #(
  parameter int unsigned ROWS    = 6,
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned LEVELS  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // led_index[5:0], led_lit[6], scale_index[12:7], scale_value[20:13]
  input  logic [lmfs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // column[2:0], row0_level[10:3], row1_level[18:11], row2_level[26:19],
  // row3_level[34:27], row4_level[42:35], row5_level[50:43]
  output logic [lmfs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [lmfs_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lmfs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import lmfs_pkg::*;

  localparam int unsigned COL_W = $clog2(COLUMNS > 1 ? COLUMNS : 2);

  top_st_e st_q, st_d;
  cmd_e    cmd_q;
  cfg_t    cfg_q;
  req_t    req;
  stat_t   stat;
  logic    s_acc, m_acc;

  logic [COL_W-1:0]   col_q;
  logic [LEVEL_W-1:0] lvl_q [OUT_ROWS];

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    req.command     = cmd_e'(s_axis_tuser);
    req.led_index   = s_axis_tdata[5:0];
    req.led_lit     = s_axis_tdata[6];
    req.scale_index = s_axis_tdata[12:7];
    req.scale_value = s_axis_tdata[20:13];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FADE_STEP: cfg_q.fade_step  <= cfg_wdata_i[STEP_W-1:0];
        REG_INVERT:    cfg_q.invert_pwm <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      T_IDLE: if (s_acc) st_d = T_BUSY;
      T_BUSY: begin
        if (stat.done) begin
          st_d = (cmd_q == CMD_SCAN) ? T_OUT : T_IDLE;
        end
      end
      T_OUT:   if (m_axis_tready) st_d = T_IDLE;
      default: st_d = T_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == T_IDLE);
    m_axis_tvalid = (st_q == T_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= T_IDLE;
      cmd_q <= CMD_NONE;
      col_q <= '0;
    end else begin
      st_q <= st_d;
      if (s_acc) begin
        cmd_q <= req.command;
      end
      // advance the column once its result is taken
      if (m_acc) begin
        col_q <= (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
      end
    end
  end

  // rows the engine does not report stay at zero
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < OUT_ROWS; r++) begin
      if (s_acc && req.command == CMD_SCAN) begin
        lvl_q[r] <= '0;
      end else if (stat.row_vld && stat.row_idx == ROW_IDX_W'(r)) begin
        lvl_q[r] <= stat.level;
      end
    end
  end

  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[2:0]   = 3'(col_q);
    for (int r = 0; r < OUT_ROWS; r++) begin
      m_axis_tdata[3 + r*LEVEL_W +: LEVEL_W] = lvl_q[r];
    end
  end

  lmfs_row_engine #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .LEVELS  (LEVELS)
  ) u_row_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc),
    .req_i   (req),
    .col_i   (col_q),
    .cfg_i   (cfg_q),
    .stat_o  (stat)
  );

endmodule

### hw/rtl/lmfs_row_engine.sv
// ----------------------------------------------------------------------------
// LED matrix fade scanner row engine
// Holds the per-LED target/fade memory and the scale table, and runs one
// request: a scale write, a target update, or a column scan that walks the
// rows through a shared fade stepper one row per cycle.
// ----------------------------------------------------------------------------
module lmfs_row_engine #(
  parameter int unsigned ROWS    = 6,
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned LEVELS  = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  lmfs_pkg::req_t                             req_i,
  input  logic [$clog2(COLUMNS > 1 ? COLUMNS : 2)-1:0] col_i,
  input  lmfs_pkg::cfg_t                             cfg_i,
  output lmfs_pkg::stat_t                            stat_o
);
  import lmfs_pkg::*;

  localparam int unsigned LED_COUNT = ROWS * COLUMNS;
  localparam int unsigned LED_W     = $clog2(LED_COUNT > 1 ? LED_COUNT : 2);
  localparam int unsigned CNT_W     = $clog2(LEVELS);
  localparam int unsigned ENTRY_W   = CNT_W + 1;
  localparam int unsigned ROWC_W    = $clog2(ROWS + 1);
  localparam int unsigned SUM_W     = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;
  localparam int unsigned LIDX_W    = LED_W + 6;
  localparam int unsigned SIDX_W    = CNT_W + 6;

  eng_st_e st_q, st_d;
  req_t    req_q;

  // fade memory: {target lit, fade counter} per LED
  logic [ENTRY_W-1:0] fade_mem [LED_COUNT];
  logic [LED_COUNT-1:0] fm_vld_q;
  logic [ENTRY_W-1:0] fm_rdata_q;
  logic               fm_rvld_q;
  logic [LED_W-1:0]   fm_raddr;
  logic               fm_we;
  logic [LED_W-1:0]   fm_waddr;
  logic [ENTRY_W-1:0] fm_wdata;

  logic [LEVEL_W-1:0] scale_mem [LEVELS];
  logic [LEVELS-1:0]  sc_vld_q;
  logic [LEVEL_W-1:0] sc_rdata_q;
  logic               sc_rvld_q;
  logic               sc_we;

  logic [ROWC_W-1:0]    issue_cnt_q;
  logic [LED_W-1:0]     led_q;
  logic                 issue;
  logic                 s1_vld_q, s2_vld_q;
  logic [ROW_IDX_W-1:0] s1_row_q, s2_row_q;
  logic [LED_W-1:0]     s1_led_q;
  logic                 s2_full_q;

  logic [LIDX_W-1:0] lidx_ext;
  logic [SIDX_W-1:0] sidx_ext;
  logic              led_in_range, scale_in_range;
  logic              scan_done;

  logic [ENTRY_W-1:0] s1_entry;
  logic               s1_lit;
  logic [CNT_W-1:0]   s1_cnt;
  logic [SUM_W-1:0]   cnt_w, step_w, goal_w, sum_w, nxt_w;
  logic [ENTRY_W-1:0] set_entry;
  logic [LEVEL_W-1:0] sc_val, s2_level;

  assign lidx_ext       = LIDX_W'(req_q.led_index);
  assign sidx_ext       = SIDX_W'(req_q.scale_index);
  assign led_in_range   = lidx_ext < LIDX_W'(LED_COUNT);
  assign scale_in_range = sidx_ext < SIDX_W'(LEVELS);
  assign scan_done      = (issue_cnt_q == ROWC_W'(ROWS)) && !s1_vld_q && !s2_vld_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      E_IDLE: begin
        if (start_i) begin
          unique case (req_i.command)
            CMD_SCAN:  st_d = E_SCAN;
            CMD_SET:   st_d = E_SET_RD;
            CMD_SCALE: st_d = E_SCALE;
            CMD_NONE:  st_d = E_DONE;
          endcase
        end
      end
      E_SCALE:  st_d = E_DONE;
      E_SET_RD: st_d = led_in_range ? E_SET_WR : E_DONE;
      E_SET_WR: st_d = E_DONE;
      E_SCAN:   st_d = scan_done ? E_DONE : E_SCAN;
      E_DONE:   st_d = E_IDLE;
      default:  st_d = E_IDLE;
    endcase
  end

  always_comb begin
    issue    = 1'b0;
    fm_we    = 1'b0;
    fm_waddr = s1_led_q;
    fm_wdata = {s1_lit, nxt_w[CNT_W-1:0]};
    fm_raddr = led_q;
    sc_we    = 1'b0;
    unique case (st_q)
      E_SCALE:  sc_we = scale_in_range;
      E_SET_RD: fm_raddr = lidx_ext[LED_W-1:0];
      E_SET_WR: begin
        fm_we    = 1'b1;
        fm_waddr = lidx_ext[LED_W-1:0];
        fm_wdata = set_entry;
      end
      E_SCAN: begin
        issue = issue_cnt_q < ROWC_W'(ROWS);
        fm_we = s1_vld_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= E_IDLE;
      issue_cnt_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
    end else begin
      st_q     <= st_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (st_q == E_IDLE && start_i) begin
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == E_IDLE && start_i) begin
      req_q <= req_i;
      led_q <= LED_W'(col_i);
    end else if (issue) begin
      led_q <= led_q + LED_W'(COLUMNS);
    end
    s1_row_q  <= ROW_IDX_W'(issue_cnt_q);
    s1_led_q  <= led_q;
    s2_row_q  <= s1_row_q;
    s2_full_q <= (cfg_i.fade_step == '0) && s1_lit;
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fade_mem[fm_waddr] <= fm_wdata;
    end
    fm_rdata_q <= fade_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      scale_mem[sidx_ext[CNT_W-1:0]] <= req_q.scale_value;
    end
    sc_rdata_q <= scale_mem[s1_cnt];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_vld_q  <= '0;
      fm_rvld_q <= 1'b0;
      sc_vld_q  <= '0;
      sc_rvld_q <= 1'b0;
    end else begin
      if (fm_we) begin
        fm_vld_q[fm_waddr] <= 1'b1;
      end
      if (sc_we) begin
        sc_vld_q[sidx_ext[CNT_W-1:0]] <= 1'b1;
      end
      fm_rvld_q <= fm_vld_q[fm_raddr];
      sc_rvld_q <= sc_vld_q[s1_cnt];
    end
  end

  // ---------------------------------------------------------------- fade stepper
  assign s1_entry  = fm_rvld_q ? fm_rdata_q : '0;
  assign s1_lit    = s1_entry[CNT_W];
  assign s1_cnt    = s1_entry[CNT_W-1:0];
  assign set_entry = {req_q.led_lit, s1_cnt};

  assign cnt_w  = SUM_W'(s1_cnt);
  assign step_w = SUM_W'(cfg_i.fade_step);
  assign goal_w = s1_lit ? SUM_W'(LEVELS - 1) : '0;
  assign sum_w  = cnt_w + step_w;

  // move toward the goal, clamp at the goal and at zero
  always_comb begin
    priority if (cnt_w < goal_w) begin
      nxt_w = (sum_w > goal_w) ? goal_w : sum_w;
    end else if (cnt_w > goal_w) begin
      nxt_w = (cnt_w < step_w) ? '0 : cnt_w - step_w;
    end else begin
      nxt_w = cnt_w;
    end
  end

  // ---------------------------------------------------------------- level
  assign sc_val = sc_rvld_q ? sc_rdata_q : '0;

  always_comb begin
    priority if (s2_full_q) begin
      s2_level = FULL_ON;
    end else if (sc_val == '0) begin
      s2_level = '0;
    end else if (sc_val == FULL_ON) begin
      s2_level = FULL_ON;
    end else if (cfg_i.invert_pwm) begin
      s2_level = FULL_ON - sc_val;
    end else begin
      s2_level = sc_val;
    end
  end

  always_comb begin
    stat_o.done    = (st_q == E_DONE);
    stat_o.row_vld = s2_vld_q;
    stat_o.row_idx = s2_row_q;
    stat_o.level   = s2_level;
  end

endmodule

### hw/rtl/lmfs_checker.sv
// ----------------------------------------------------------------------------
// LED matrix fade scanner port checker
// Watches the stream ports for a held stalled result and for ordering between requests and results.
// ----------------------------------------------------------------------------
module lmfs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lmfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: never take a request while a result waits
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request ready while result pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready held after accepted request");

  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after result taken");

endmodule

bind led_matrix_fade_scanner lmfs_checker u_lmfs_checker (.*);
